// ----- design/ecpa_pkg.sv -----
// Package for the elliptic-curve point unit: microcode format, register map and control ROM.
package ecpa_pkg;

  localparam int W = 32;
  localparam int RA_W = 5;
  localparam int PC_W = 7;
  localparam int RF_DEPTH = 1 << RA_W;

  typedef enum logic [3:0] {
    OP_LDI, OP_ADD, OP_SUB, OP_MUL, OP_RED, OP_DIV, OP_GETR, OP_SHR, OP_MOV,
    OP_BR, OP_JMP, OP_CALL, OP_RET, OP_DONE
  } op_e;

  typedef enum logic [2:0] {
    C_ALW, C_MZ, C_OPADD, C_AZ, C_BIT0Z, C_BZ, C_NE, C_NE1
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cnd;
    logic [RA_W-1:0] dst;
    logic [RA_W-1:0] ra;
    logic [RA_W-1:0] rb;
    logic            ina;
    logic [PC_W-1:0] tgt;
    logic            imm;
  } uword_t;

  // register file map
  localparam logic [RA_W-1:0] R_PX   = 5'd0;
  localparam logic [RA_W-1:0] R_PY   = 5'd1;
  localparam logic [RA_W-1:0] R_QX   = 5'd2;
  localparam logic [RA_W-1:0] R_QY   = 5'd3;
  localparam logic [RA_W-1:0] R_A    = 5'd4;
  localparam logic [RA_W-1:0] R_K    = 5'd5;
  localparam logic [RA_W-1:0] R_ACX  = 5'd6;
  localparam logic [RA_W-1:0] R_ACY  = 5'd7;
  localparam logic [RA_W-1:0] R_RNX  = 5'd8;
  localparam logic [RA_W-1:0] R_RNY  = 5'd9;
  localparam logic [RA_W-1:0] R_IX   = 5'd10;
  localparam logic [RA_W-1:0] R_IY   = 5'd11;
  localparam logic [RA_W-1:0] R_NUM  = 5'd12;
  localparam logic [RA_W-1:0] R_DEN  = 5'd13;
  localparam logic [RA_W-1:0] R_T0   = 5'd14;
  localparam logic [RA_W-1:0] R_T1   = 5'd15;
  localparam logic [RA_W-1:0] R_R0   = 5'd16;
  localparam logic [RA_W-1:0] R_R1   = 5'd17;
  localparam logic [RA_W-1:0] R_Q    = 5'd18;
  localparam logic [RA_W-1:0] R_TMP  = 5'd19;
  localparam logic [RA_W-1:0] R_LAM  = 5'd20;
  localparam logic [RA_W-1:0] R_X3   = 5'd21;
  localparam logic [RA_W-1:0] R_Y3   = 5'd22;
  localparam logic [RA_W-1:0] R_ZERO = 5'd23;

  // external operand sources (ra with ina set)
  localparam logic [RA_W-1:0] X_PX = 5'd0;
  localparam logic [RA_W-1:0] X_PY = 5'd1;
  localparam logic [RA_W-1:0] X_QX = 5'd2;
  localparam logic [RA_W-1:0] X_QY = 5'd3;
  localparam logic [RA_W-1:0] X_K  = 5'd4;
  localparam logic [RA_W-1:0] X_A  = 5'd5;
  localparam logic [RA_W-1:0] X_M  = 5'd6;

  // program labels
  localparam logic [PC_W-1:0] L_LOOP   = 7'd11;
  localparam logic [PC_W-1:0] L_DBL    = 7'd20;
  localparam logic [PC_W-1:0] L_FIN    = 7'd29;
  localparam logic [PC_W-1:0] L_ADDOP  = 7'd30;
  localparam logic [PC_W-1:0] L_ZERO   = 7'd36;
  localparam logic [PC_W-1:0] L_PSUM   = 7'd39;
  localparam logic [PC_W-1:0] L_CHORD  = 7'd51;
  localparam logic [PC_W-1:0] L_INV    = 7'd53;
  localparam logic [PC_W-1:0] L_ELOOP  = 7'd58;
  localparam logic [PC_W-1:0] L_EEND   = 7'd69;
  localparam logic [PC_W-1:0] L_NOINV  = 7'd72;
  localparam logic [PC_W-1:0] L_SLOPE  = 7'd73;
  localparam logic [PC_W-1:0] L_RETQ   = 7'd80;
  localparam logic [PC_W-1:0] L_RETP   = 7'd83;
  localparam logic [PC_W-1:0] L_RETINF = 7'd86;

  localparam logic [PC_W-1:0] NO_T = '0;
  localparam logic [RA_W-1:0] NO_R = '0;

  function automatic uword_t mk(op_e op, cond_e cnd, logic [RA_W-1:0] dst,
                                logic [RA_W-1:0] ra, logic [RA_W-1:0] rb, logic ina,
                                logic [PC_W-1:0] tgt, logic imm);
    uword_t w;
    w.op  = op;
    w.cnd = cnd;
    w.dst = dst;
    w.ra  = ra;
    w.rb  = rb;
    w.ina = ina;
    w.tgt = tgt;
    w.imm = imm;
    return w;
  endfunction

  function automatic uword_t ucode(logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      7'd0:  w = mk(OP_BR,   C_MZ,    NO_R,   NO_R,   NO_R,   1'b0, L_ZERO,   1'b0);
      7'd1:  w = mk(OP_LDI,  C_ALW,   R_ZERO, NO_R,   NO_R,   1'b0, NO_T,     1'b0);
      7'd2:  w = mk(OP_RED,  C_ALW,   R_A,    X_A,    NO_R,   1'b1, NO_T,     1'b0);
      7'd3:  w = mk(OP_RED,  C_ALW,   R_IX,   X_PX,   NO_R,   1'b1, NO_T,     1'b0);
      7'd4:  w = mk(OP_RED,  C_ALW,   R_IY,   X_PY,   NO_R,   1'b1, NO_T,     1'b0);
      7'd5:  w = mk(OP_BR,   C_OPADD, NO_R,   NO_R,   NO_R,   1'b0, L_ADDOP,  1'b0);
      7'd6:  w = mk(OP_LDI,  C_ALW,   R_ACX,  NO_R,   NO_R,   1'b0, NO_T,     1'b0);
      7'd7:  w = mk(OP_LDI,  C_ALW,   R_ACY,  NO_R,   NO_R,   1'b0, NO_T,     1'b0);
      7'd8:  w = mk(OP_MOV,  C_ALW,   R_RNX,  R_IX,   NO_R,   1'b0, NO_T,     1'b0);
      7'd9:  w = mk(OP_MOV,  C_ALW,   R_RNY,  R_IY,   NO_R,   1'b0, NO_T,     1'b0);
      7'd10: w = mk(OP_MOV,  C_ALW,   R_K,    X_K,    NO_R,   1'b1, NO_T,     1'b0);
      7'd11: w = mk(OP_BR,   C_AZ,    NO_R,   R_K,    NO_R,   1'b0, L_FIN,    1'b0);
      7'd12: w = mk(OP_BR,   C_BIT0Z, NO_R,   R_K,    NO_R,   1'b0, L_DBL,    1'b0);
      7'd13: w = mk(OP_MOV,  C_ALW,   R_PX,   R_ACX,  NO_R,   1'b0, NO_T,     1'b0);
      7'd14: w = mk(OP_MOV,  C_ALW,   R_PY,   R_ACY,  NO_R,   1'b0, NO_T,     1'b0);
      7'd15: w = mk(OP_MOV,  C_ALW,   R_QX,   R_RNX,  NO_R,   1'b0, NO_T,     1'b0);
      7'd16: w = mk(OP_MOV,  C_ALW,   R_QY,   R_RNY,  NO_R,   1'b0, NO_T,     1'b0);
      7'd17: w = mk(OP_CALL, C_ALW,   NO_R,   NO_R,   NO_R,   1'b0, L_PSUM,   1'b0);
      7'd18: w = mk(OP_MOV,  C_ALW,   R_ACX,  R_X3,   NO_R,   1'b0, NO_T,     1'b0);
      7'd19: w = mk(OP_MOV,  C_ALW,   R_ACY,  R_Y3,   NO_R,   1'b0, NO_T,     1'b0);
      7'd20: w = mk(OP_MOV,  C_ALW,   R_PX,   R_RNX,  NO_R,   1'b0, NO_T,     1'b0);
      7'd21: w = mk(OP_MOV,  C_ALW,   R_PY,   R_RNY,  NO_R,   1'b0, NO_T,     1'b0);
      7'd22: w = mk(OP_MOV,  C_ALW,   R_QX,   R_RNX,  NO_R,   1'b0, NO_T,     1'b0);
      7'd23: w = mk(OP_MOV,  C_ALW,   R_QY,   R_RNY,  NO_R,   1'b0, NO_T,     1'b0);
      7'd24: w = mk(OP_CALL, C_ALW,   NO_R,   NO_R,   NO_R,   1'b0, L_PSUM,   1'b0);
      7'd25: w = mk(OP_MOV,  C_ALW,   R_RNX,  R_X3,   NO_R,   1'b0, NO_T,     1'b0);
      7'd26: w = mk(OP_MOV,  C_ALW,   R_RNY,  R_Y3,   NO_R,   1'b0, NO_T,     1'b0);
      7'd27: w = mk(OP_SHR,  C_ALW,   R_K,    R_K,    NO_R,   1'b0, NO_T,     1'b0);
      7'd28: w = mk(OP_JMP,  C_ALW,   NO_R,   NO_R,   NO_R,   1'b0, L_LOOP,   1'b0);
      7'd29: w = mk(OP_DONE, C_ALW,   NO_R,   R_ACX,  R_ACY,  1'b0, NO_T,     1'b0);
      7'd30: w = mk(OP_RED,  C_ALW,   R_QX,   X_QX,   NO_R,   1'b1, NO_T,     1'b0);
      7'd31: w = mk(OP_RED,  C_ALW,   R_QY,   X_QY,   NO_R,   1'b1, NO_T,     1'b0);
      7'd32: w = mk(OP_MOV,  C_ALW,   R_PX,   R_IX,   NO_R,   1'b0, NO_T,     1'b0);
      7'd33: w = mk(OP_MOV,  C_ALW,   R_PY,   R_IY,   NO_R,   1'b0, NO_T,     1'b0);
      7'd34: w = mk(OP_CALL, C_ALW,   NO_R,   NO_R,   NO_R,   1'b0, L_PSUM,   1'b0);
      7'd35: w = mk(OP_DONE, C_ALW,   NO_R,   R_X3,   R_Y3,   1'b0, NO_T,     1'b0);
      7'd36: w = mk(OP_LDI,  C_ALW,   R_X3,   NO_R,   NO_R,   1'b0, NO_T,     1'b0);
      7'd37: w = mk(OP_LDI,  C_ALW,   R_Y3,   NO_R,   NO_R,   1'b0, NO_T,     1'b0);
      7'd38: w = mk(OP_DONE, C_ALW,   NO_R,   R_X3,   R_Y3,   1'b0, NO_T,     1'b0);
      // point sum subroutine
      7'd39: w = mk(OP_BR,   C_BZ,    NO_R,   R_PX,   R_PY,   1'b0, L_RETQ,   1'b0);
      7'd40: w = mk(OP_BR,   C_BZ,    NO_R,   R_QX,   R_QY,   1'b0, L_RETP,   1'b0);
      7'd41: w = mk(OP_BR,   C_NE,    NO_R,   R_PX,   R_QX,   1'b0, L_CHORD,  1'b0);
      7'd42: w = mk(OP_ADD,  C_ALW,   R_TMP,  R_PY,   R_QY,   1'b0, NO_T,     1'b0);
      7'd43: w = mk(OP_BR,   C_AZ,    NO_R,   R_TMP,  NO_R,   1'b0, L_RETINF, 1'b0);
      7'd44: w = mk(OP_BR,   C_NE,    NO_R,   R_PY,   R_QY,   1'b0, L_CHORD,  1'b0);
      7'd45: w = mk(OP_MUL,  C_ALW,   R_TMP,  R_PX,   R_PX,   1'b0, NO_T,     1'b0);
      7'd46: w = mk(OP_ADD,  C_ALW,   R_NUM,  R_TMP,  R_TMP,  1'b0, NO_T,     1'b0);
      7'd47: w = mk(OP_ADD,  C_ALW,   R_NUM,  R_NUM,  R_TMP,  1'b0, NO_T,     1'b0);
      7'd48: w = mk(OP_ADD,  C_ALW,   R_NUM,  R_NUM,  R_A,    1'b0, NO_T,     1'b0);
      7'd49: w = mk(OP_ADD,  C_ALW,   R_DEN,  R_PY,   R_PY,   1'b0, NO_T,     1'b0);
      7'd50: w = mk(OP_JMP,  C_ALW,   NO_R,   NO_R,   NO_R,   1'b0, L_INV,    1'b0);
      7'd51: w = mk(OP_SUB,  C_ALW,   R_NUM,  R_QY,   R_PY,   1'b0, NO_T,     1'b0);
      7'd52: w = mk(OP_SUB,  C_ALW,   R_DEN,  R_QX,   R_PX,   1'b0, NO_T,     1'b0);
      // extended Euclid
      7'd53: w = mk(OP_MOV,  C_ALW,   R_R0,   X_M,    NO_R,   1'b1, NO_T,     1'b0);
      7'd54: w = mk(OP_MOV,  C_ALW,   R_R1,   R_DEN,  NO_R,   1'b0, NO_T,     1'b0);
      7'd55: w = mk(OP_LDI,  C_ALW,   R_T0,   NO_R,   NO_R,   1'b0, NO_T,     1'b0);
      7'd56: w = mk(OP_LDI,  C_ALW,   R_TMP,  NO_R,   NO_R,   1'b0, NO_T,     1'b1);
      7'd57: w = mk(OP_ADD,  C_ALW,   R_T1,   R_TMP,  R_ZERO, 1'b0, NO_T,     1'b0);
      7'd58: w = mk(OP_BR,   C_AZ,    NO_R,   R_R1,   NO_R,   1'b0, L_EEND,   1'b0);
      7'd59: w = mk(OP_DIV,  C_ALW,   R_Q,    R_R0,   R_R1,   1'b0, NO_T,     1'b0);
      7'd60: w = mk(OP_GETR, C_ALW,   R_TMP,  NO_R,   NO_R,   1'b0, NO_T,     1'b0);
      7'd61: w = mk(OP_MOV,  C_ALW,   R_R0,   R_R1,   NO_R,   1'b0, NO_T,     1'b0);
      7'd62: w = mk(OP_MOV,  C_ALW,   R_R1,   R_TMP,  NO_R,   1'b0, NO_T,     1'b0);
      7'd63: w = mk(OP_ADD,  C_ALW,   R_Q,    R_Q,    R_ZERO, 1'b0, NO_T,     1'b0);
      7'd64: w = mk(OP_MUL,  C_ALW,   R_Q,    R_Q,    R_T1,   1'b0, NO_T,     1'b0);
      7'd65: w = mk(OP_SUB,  C_ALW,   R_TMP,  R_T0,   R_Q,    1'b0, NO_T,     1'b0);
      7'd66: w = mk(OP_MOV,  C_ALW,   R_T0,   R_T1,   NO_R,   1'b0, NO_T,     1'b0);
      7'd67: w = mk(OP_MOV,  C_ALW,   R_T1,   R_TMP,  NO_R,   1'b0, NO_T,     1'b0);
      7'd68: w = mk(OP_JMP,  C_ALW,   NO_R,   NO_R,   NO_R,   1'b0, L_ELOOP,  1'b0);
      7'd69: w = mk(OP_BR,   C_NE1,   NO_R,   R_R0,   NO_R,   1'b0, L_NOINV,  1'b0);
      7'd70: w = mk(OP_MUL,  C_ALW,   R_LAM,  R_NUM,  R_T0,   1'b0, NO_T,     1'b0);
      7'd71: w = mk(OP_JMP,  C_ALW,   NO_R,   NO_R,   NO_R,   1'b0, L_SLOPE,  1'b0);
      7'd72: w = mk(OP_LDI,  C_ALW,   R_LAM,  NO_R,   NO_R,   1'b0, NO_T,     1'b0);
      7'd73: w = mk(OP_MUL,  C_ALW,   R_TMP,  R_LAM,  R_LAM,  1'b0, NO_T,     1'b0);
      7'd74: w = mk(OP_SUB,  C_ALW,   R_TMP,  R_TMP,  R_PX,   1'b0, NO_T,     1'b0);
      7'd75: w = mk(OP_SUB,  C_ALW,   R_X3,   R_TMP,  R_QX,   1'b0, NO_T,     1'b0);
      7'd76: w = mk(OP_SUB,  C_ALW,   R_TMP,  R_PX,   R_X3,   1'b0, NO_T,     1'b0);
      7'd77: w = mk(OP_MUL,  C_ALW,   R_TMP,  R_LAM,  R_TMP,  1'b0, NO_T,     1'b0);
      7'd78: w = mk(OP_SUB,  C_ALW,   R_Y3,   R_TMP,  R_PY,   1'b0, NO_T,     1'b0);
      7'd79: w = mk(OP_RET,  C_ALW,   NO_R,   NO_R,   NO_R,   1'b0, NO_T,     1'b0);
      7'd80: w = mk(OP_MOV,  C_ALW,   R_X3,   R_QX,   NO_R,   1'b0, NO_T,     1'b0);
      7'd81: w = mk(OP_MOV,  C_ALW,   R_Y3,   R_QY,   NO_R,   1'b0, NO_T,     1'b0);
      7'd82: w = mk(OP_RET,  C_ALW,   NO_R,   NO_R,   NO_R,   1'b0, NO_T,     1'b0);
      7'd83: w = mk(OP_MOV,  C_ALW,   R_X3,   R_PX,   NO_R,   1'b0, NO_T,     1'b0);
      7'd84: w = mk(OP_MOV,  C_ALW,   R_Y3,   R_PY,   NO_R,   1'b0, NO_T,     1'b0);
      7'd85: w = mk(OP_RET,  C_ALW,   NO_R,   NO_R,   NO_R,   1'b0, NO_T,     1'b0);
      7'd86: w = mk(OP_LDI,  C_ALW,   R_X3,   NO_R,   NO_R,   1'b0, NO_T,     1'b0);
      7'd87: w = mk(OP_LDI,  C_ALW,   R_Y3,   NO_R,   NO_R,   1'b0, NO_T,     1'b0);
      7'd88: w = mk(OP_RET,  C_ALW,   NO_R,   NO_R,   NO_R,   1'b0, NO_T,     1'b0);
      default: w = mk(OP_DONE, C_ALW, NO_R,   R_X3,   R_Y3,   1'b0, NO_T,     1'b0);
    endcase
    return w;
  endfunction

endpackage

// ----- design/ec_point_add_scalar_multiply_top.sv -----
// Elliptic-curve point add / scalar multiply engine, microcoded over a serial field datapath.
//
//  channel  direction  handshake                 beat
//  in       sink       in_valid_i / in_ready_o   operation, p_x, p_y, q_x, q_y, scalar
//  out      source     out_valid_o / out_ready_i res_x, res_y, is_identity
//  cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Each microstep reads its operands in ST_RD and then executes in ST_EX; field multiply,
// divide and reduce iterate in ST_EX one bit a cycle. A point sum that needs a slope is
// dominated by the inverse loop; a scalar multiply runs up to 64 point sums.
// One item at a time; in_ready_o is high while the sequencer is idle.
// Reset clears control and loads the modulus and curve_a defaults; no clearing pass.
// A pending result holds the sequencer at its final step until the out beat is taken.
module ec_point_add_scalar_multiply_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [31:0] p_x_i,
  input  logic [31:0] p_y_i,
  input  logic [31:0] q_x_i,
  input  logic [31:0] q_y_i,
  input  logic [31:0] scalar_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] res_x_o,
  output logic [31:0] res_y_o,
  output logic        is_identity_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int W = ecpa_pkg::W;
  localparam int PC_W = ecpa_pkg::PC_W;
  localparam int CNT_W = $clog2(W);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_EX   = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [PC_W-1:0]   pc_q, pc_d, ret_q, ret_d;
  logic [CNT_W-1:0]  cnt_q;
  logic [W-1:0]      acc_q, quo_q, opa_q, opb_q;
  logic              op_q;
  logic [W-1:0]      px_q, py_q, qx_q, qy_q, k_q;
  logic [W-1:0]      m_q, ca_q;
  logic [W-1:0]      rx_q, ry_q;
  logic              oid_q, ov_q;
  logic [W-1:0]      rf [ecpa_pkg::RF_DEPTH];

  ecpa_pkg::uword_t  uw;
  logic [W-1:0]      ext_val;
  logic              serial_op;
  logic [CNT_W-1:0]  bit_idx;
  logic [W:0]        m_ext, mt, mtr, mu, mur, dt, dts, d_ext;
  logic              qb;
  logic [W-1:0]      step_nx, quo_nx;
  logic [W:0]        add_s, add_m, sub_p;
  logic [W-1:0]      alu_add, alu_sub;
  logic              cond_ok;
  logic              rf_we, ld_out;
  logic [W-1:0]      rf_wd;

  assign uw = ecpa_pkg::ucode(pc_q);
  assign serial_op = (uw.op == ecpa_pkg::OP_MUL) || (uw.op == ecpa_pkg::OP_DIV) ||
                     (uw.op == ecpa_pkg::OP_RED);

  always_comb begin
    case (uw.ra)
      ecpa_pkg::X_PX: ext_val = px_q;
      ecpa_pkg::X_PY: ext_val = py_q;
      ecpa_pkg::X_QX: ext_val = qx_q;
      ecpa_pkg::X_QY: ext_val = qy_q;
      ecpa_pkg::X_K:  ext_val = k_q;
      ecpa_pkg::X_A:  ext_val = ca_q;
      default:        ext_val = m_q;
    endcase
  end

  // serial unit: interleaved modular multiply, restoring divide / reduce
  always_comb begin
    bit_idx = ~cnt_q;
    m_ext   = {1'b0, m_q};
    mt      = {acc_q, 1'b0};
    mtr     = (mt >= m_ext) ? (mt - m_ext) : mt;
    mu      = mtr + (opb_q[bit_idx] ? {1'b0, opa_q} : '0);
    mur     = (mu >= m_ext) ? (mu - m_ext) : mu;
    d_ext   = (uw.op == ecpa_pkg::OP_RED) ? m_ext : {1'b0, opb_q};
    dt      = {acc_q, opa_q[bit_idx]};
    qb      = (dt >= d_ext);
    dts     = dt - d_ext;
    step_nx = (uw.op == ecpa_pkg::OP_MUL) ? mur[W-1:0] : (qb ? dts[W-1:0] : dt[W-1:0]);
    quo_nx  = {quo_q[W-2:0], qb};
  end

  always_comb begin
    add_s   = {1'b0, opa_q} + {1'b0, opb_q};
    add_m   = add_s - m_ext;
    alu_add = (add_s >= m_ext) ? add_m[W-1:0] : add_s[W-1:0];
    sub_p   = {1'b0, opa_q} + m_ext - {1'b0, opb_q};
    alu_sub = (opa_q >= opb_q) ? (opa_q - opb_q) : sub_p[W-1:0];
  end

  always_comb begin
    case (uw.cnd)
      ecpa_pkg::C_ALW:   cond_ok = 1'b1;
      ecpa_pkg::C_MZ:    cond_ok = (m_q == '0);
      ecpa_pkg::C_OPADD: cond_ok = op_q;
      ecpa_pkg::C_AZ:    cond_ok = (opa_q == '0);
      ecpa_pkg::C_BIT0Z: cond_ok = !opa_q[0];
      ecpa_pkg::C_BZ:    cond_ok = (opa_q == '0) && (opb_q == '0);
      ecpa_pkg::C_NE:    cond_ok = (opa_q != opb_q);
      ecpa_pkg::C_NE1:   cond_ok = (opa_q != W'(1));
      default:           cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    ret_d   = ret_q;
    rf_we   = 1'b0;
    rf_wd   = '0;
    ld_out  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RD;
          pc_d    = '0;
        end
      end
      ST_RD: begin
        state_d = ST_EX;
      end
      ST_EX: begin
        state_d = ST_RD;
        pc_d    = pc_q + PC_W'(1);
        case (uw.op)
          ecpa_pkg::OP_LDI: begin
            rf_we = 1'b1;
            rf_wd = W'(uw.imm);
          end
          ecpa_pkg::OP_ADD: begin
            rf_we = 1'b1;
            rf_wd = alu_add;
          end
          ecpa_pkg::OP_SUB: begin
            rf_we = 1'b1;
            rf_wd = alu_sub;
          end
          ecpa_pkg::OP_SHR: begin
            rf_we = 1'b1;
            rf_wd = opa_q >> 1;
          end
          ecpa_pkg::OP_MOV: begin
            rf_we = 1'b1;
            rf_wd = opa_q;
          end
          ecpa_pkg::OP_GETR: begin
            rf_we = 1'b1;
            rf_wd = acc_q;
          end
          ecpa_pkg::OP_MUL, ecpa_pkg::OP_DIV, ecpa_pkg::OP_RED: begin
            if (cnt_q == '1) begin
              rf_we = 1'b1;
              rf_wd = (uw.op == ecpa_pkg::OP_DIV) ? quo_nx : step_nx;
            end else begin
              state_d = ST_EX;
              pc_d    = pc_q;
            end
          end
          ecpa_pkg::OP_BR: begin
            if (cond_ok) begin
              pc_d = uw.tgt;
            end
          end
          ecpa_pkg::OP_JMP: begin
            pc_d = uw.tgt;
          end
          ecpa_pkg::OP_CALL: begin
            ret_d = pc_q + PC_W'(1);
            pc_d  = uw.tgt;
          end
          ecpa_pkg::OP_RET: begin
            pc_d = ret_q;
          end
          ecpa_pkg::OP_DONE: begin
            pc_d = pc_q;
            if (!ov_q || out_ready_i) begin
              ld_out  = 1'b1;
              state_d = ST_IDLE;
            end else begin
              state_d = ST_EX;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      ret_q   <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      m_q     <= W'(524287);
      ca_q    <= W'(5);
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      ret_q   <= ret_d;
      if (state_q == ST_RD) begin
        cnt_q <= '0;
      end else if (state_q == ST_EX) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (ld_out) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        if (cfg_index_i) begin
          ca_q <= cfg_data_i;
        end else begin
          m_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      op_q <= operation_i;
      px_q <= p_x_i;
      py_q <= p_y_i;
      qx_q <= q_x_i;
      qy_q <= q_y_i;
      k_q  <= scalar_i;
    end
    if (state_q == ST_RD) begin
      opa_q <= uw.ina ? ext_val : rf[uw.ra];
      opb_q <= rf[uw.rb];
      if (serial_op) begin
        acc_q <= '0;
        quo_q <= '0;
      end
    end else if (state_q == ST_EX && serial_op) begin
      acc_q <= step_nx;
      quo_q <= quo_nx;
    end
    if (rf_we) begin
      rf[uw.dst] <= rf_wd;
    end
    if (ld_out) begin
      rx_q  <= opa_q;
      ry_q  <= opb_q;
      oid_q <= (opa_q == '0) && (opb_q == '0);
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = ov_q;
  assign res_x_o       = rx_q;
  assign res_y_o       = ry_q;
  assign is_identity_o = oid_q;
  assign cfg_ready_o   = 1'b1;

endmodule

// ----- design/ecpa_chk.sv -----
// Port-level checker for the elliptic-curve point engine, bound to the top level.
module ecpa_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] res_x_o,
  input logic [31:0] res_y_o,
  input logic        is_identity_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_x_o) && $stable(res_y_o))
    else $error("result beat changed while stalled");

  a_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_identity_o == ((res_x_o == '0) && (res_y_o == '0))))
    else $error("identity flag disagrees with coordinates");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> ##1 !out_valid_o || $stable(res_x_o))
    else $error("result appeared too soon after input");

endmodule

bind ec_point_add_scalar_multiply_top ecpa_chk u_ecpa_chk (.*);

// ----- tb/tb.sv -----
// Testbench for the elliptic-curve point add / scalar multiply engine.
`timescale 1ns / 1ps

module tb;

  typedef longint unsigned u64;

  typedef struct {
    logic        op;
    logic [31:0] px, py, qx, qy, k;
    bit          known;
    logic [31:0] ex, ey;
    logic        eid;
  } vec_t;

  typedef struct {
    logic [31:0] rx, ry;
    logic        id;
  } pt_res_t;

  localparam logic OP_MULT = 1'b0;
  localparam logic OP_PADD = 1'b1;
  localparam logic REG_MOD = 1'b0;
  localparam logic REG_A   = 1'b1;
  localparam int   WDOG_LIMIT = 2000000;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o, operation_i;
  logic [31:0] p_x_i, p_y_i, q_x_i, q_y_i, scalar_i;
  logic        out_valid_o, out_ready_i, is_identity_o;
  logic [31:0] res_x_o, res_y_o;
  logic        cfg_valid_i, cfg_ready_o, cfg_index_i;
  logic [31:0] cfg_data_i;

  logic        s_in_rdy, s_out_vld, s_cfg_rdy, s_id;
  logic [31:0] s_rx, s_ry;

  u64      fmod, fa;
  pt_res_t pending_pts[$];
  int      err_cnt, gap_pct, stall_pct, idle_cyc;

  ec_point_add_scalar_multiply_top dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    s_in_rdy  = in_ready_o;
    s_out_vld = out_valid_o;
    s_cfg_rdy = cfg_ready_o;
    s_rx      = res_x_o;
    s_ry      = res_y_o;
    s_id      = is_identity_o;
  end

  function automatic u64 msub(u64 x, u64 y, u64 m);
    return (x + m - y) % m;
  endfunction

  function automatic void psum(u64 px, u64 py, u64 qx, u64 qy, u64 a, u64 m,
                               output u64 rx, output u64 ry);
    u64 num, den, lam, r0, r1, t0, t1, q, nr, nt;
    if (px == 0 && py == 0) begin rx = qx; ry = qy; return; end
    if (qx == 0 && qy == 0) begin rx = px; ry = py; return; end
    if (px == qx && (py + qy) % m == 0) begin rx = 0; ry = 0; return; end
    if (px == qx && py == qy) begin
      num = ((3 % m) * ((px * px) % m) % m + a) % m;
      den = ((2 % m) * py) % m;
    end else begin
      num = msub(qy, py, m);
      den = msub(qx, px, m);
    end
    r0 = m; r1 = den; t0 = 0; t1 = 1 % m;
    while (r1 != 0) begin
      q  = r0 / r1;
      nr = r0 - q * r1;
      nt = msub(t0, ((q % m) * t1) % m, m);
      r0 = r1; r1 = nr; t0 = t1; t1 = nt;
    end
    lam = (r0 == 1) ? (num * t0) % m : 0;
    rx = msub(msub((lam * lam) % m, px, m), qx, m);
    ry = msub((lam * msub(px, rx, m)) % m, py, m);
  endfunction

  function automatic pt_res_t ec_eval(vec_t v);
    pt_res_t r;
    u64 m, a, px, py, qx, qy, ax, ay, nx, ny, tx, ty, k;
    m = fmod;
    if (m == 0) begin
      r.rx = '0; r.ry = '0; r.id = 1'b1;
      return r;
    end
    a = fa % m;
    px = u64'(v.px) % m; py = u64'(v.py) % m;
    qx = u64'(v.qx) % m; qy = u64'(v.qy) % m;
    if (v.op == OP_PADD) begin
      psum(px, py, qx, qy, a, m, ax, ay);
    end else begin
      ax = 0; ay = 0; nx = px; ny = py; k = u64'(v.k);
      while (k != 0) begin
        if (k[0]) begin
          psum(ax, ay, nx, ny, a, m, tx, ty);
          ax = tx; ay = ty;
        end
        psum(nx, ny, nx, ny, a, m, tx, ty);
        nx = tx; ny = ty;
        k = k >> 1;
      end
    end
    r.rx = ax[31:0]; r.ry = ay[31:0]; r.id = (ax == 0 && ay == 0);
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    pt_res_t e;
    if (rst_ni && s_out_vld && out_ready_i) begin
      if (pending_pts.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result beat x=%h y=%h id=%b", s_rx, s_ry, s_id);
      end else begin
        e = pending_pts.pop_front();
        if (e.rx !== s_rx || e.ry !== s_ry || e.id !== s_id) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp x=%h y=%h id=%b got x=%h y=%h id=%b",
                     e.rx, e.ry, e.id, s_rx, s_ry, s_id);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && s_in_rdy) || (s_out_vld && out_ready_i) || (cfg_valid_i && s_cfg_rdy))
      idle_cyc <= 0;
    else
      idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_pts.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic idx, logic [31:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!s_cfg_rdy);
    cfg_valid_i <= 1'b0;
    if (idx == REG_MOD) fmod = u64'(data); else fa = u64'(data);
  endtask

  task automatic send(vec_t v);
    pt_res_t e;
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    in_valid_i  <= 1'b1;
    operation_i <= v.op;
    p_x_i <= v.px; p_y_i <= v.py; q_x_i <= v.qx; q_y_i <= v.qy; scalar_i <= v.k;
    do @(posedge clk_i); while (!s_in_rdy);
    if (v.known) begin
      e.rx = v.ex; e.ry = v.ey; e.id = v.eid;
    end else begin
      e = ec_eval(v);
    end
    pending_pts.push_back(e);
  endtask

  function automatic logic [31:0] rnd_coord();
    if (fmod == 0 || $urandom_range(7) == 0) return $urandom;
    return 32'(u64'($urandom) % fmod);
  endfunction

  function automatic vec_t rnd_vec();
    vec_t v;
    v.known = 0;
    v.op = 1'($urandom_range(1));
    v.px = rnd_coord(); v.py = rnd_coord();
    if ($urandom_range(9) == 0) begin v.px = '0; v.py = '0; end
    case ($urandom_range(4))
      0: begin v.qx = v.px; v.qy = v.py; end
      1: begin v.qx = v.px; v.qy = (fmod == 0) ? $urandom : 32'((fmod - u64'(v.py) % fmod) % fmod); end
      2: begin v.qx = '0; v.qy = '0; end
      default: begin v.qx = rnd_coord(); v.qy = rnd_coord(); end
    endcase
    case ($urandom_range(19))
      0: v.k = $urandom;
      1: v.k = '0;
      default: v.k = $urandom_range(15);
    endcase
    return v;
  endfunction

  function automatic vec_t row(logic op, logic [31:0] px, py, qx, qy, k,
                               bit known = 0, logic [31:0] ex = 0, ey = 0, logic eid = 0);
    vec_t v;
    v.op = op; v.px = px; v.py = py; v.qx = qx; v.qy = qy; v.k = k;
    v.known = known; v.ex = ex; v.ey = ey; v.eid = eid;
    return v;
  endfunction

  initial begin
    vec_t   dir_tab[$];
    u64     ph_mod[7] = '{97, 4294967291, 3, 0, 15, 4294967295, 65521};
    u64     ph_a[7]   = '{2, 4294967295, 0, 7, 1, 123, 65520};
    int     ph_gap[7] = '{0, 62, 0, 11, 11, 62, 0};
    int     ph_stl[7] = '{0, 0, 62, 11, 11, 0, 62};
    rst_ni = 1'b0; in_valid_i = 1'b0; operation_i = 1'b0;
    p_x_i = '0; p_y_i = '0; q_x_i = '0; q_y_i = '0; scalar_i = '0;
    out_ready_i = 1'b0; cfg_valid_i = 1'b0; cfg_index_i = 1'b0; cfg_data_i = '0;
    err_cnt = 0; gap_pct = 0; stall_pct = 0; idle_cyc = 0;
    fmod = 524287; fa = 5;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_tab = '{
      row(OP_PADD, 0, 0, 0, 0, 0, 1, 0, 0, 1),
      row(OP_MULT, 3, 4, 0, 0, 0, 1, 0, 0, 1),
      row(OP_PADD, 1234, 5678, 0, 0, 0, 1, 1234, 5678, 0),
      row(OP_PADD, 0, 0, 9, 10, 0, 1, 9, 10, 0),
      row(OP_PADD, 100, 200, 100, 524087, 0, 1, 0, 0, 1),
      row(OP_PADD, 5, 0, 5, 0, 0, 1, 0, 0, 1),
      row(OP_MULT, 7, 9, 0, 0, 1, 1, 7, 9, 0),
      row(OP_MULT, 0, 0, 0, 0, 5, 1, 0, 0, 1),
      row(OP_PADD, 100, 200, 100, 200, 0),
      row(OP_PADD, 11, 22, 33, 44, 32'hffffffff),
      row(OP_PADD, 524294, 524300, 3, 4, 0),
      row(OP_PADD, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff),
      row(OP_MULT, 12, 34, 32'hffffffff, 32'hffffffff, 2),
      row(OP_MULT, 12, 34, 0, 0, 32'hffffffff),
      row(OP_MULT, 56, 78, 0, 0, 32'h80000000),
      row(OP_MULT, 524286, 524286, 0, 0, 3)
    };
    foreach (dir_tab[i]) send(dir_tab[i]);

    // zero modulus and a non-invertible slope denominator
    cfg_write(REG_MOD, 0);
    send(row(OP_PADD, 1, 2, 3, 4, 0, 1, 0, 0, 1));
    send(row(OP_MULT, 1, 2, 0, 0, 9, 1, 0, 0, 1));
    cfg_write(REG_MOD, 15);
    send(row(OP_PADD, 1, 1, 4, 2, 0));
    send(row(OP_PADD, 2, 3, 2, 3, 0));

    for (int p = 0; p < 7; p++) begin
      cfg_write(REG_MOD, ph_mod[p][31:0]);
      cfg_write(REG_A, ph_a[p][31:0]);
      gap_pct = ph_gap[p];
      stall_pct = ph_stl[p];
      for (int i = 0; i < 12; i++) begin
        if (i == 6) drain();
        send(rnd_vec());
      end
    end

    in_valid_i <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
